// ----- design/mte_pkg.sv -----
// Package for the track event encoder: event codes, byte constants, job types and the
// tempo divider constants.
// It depends on nothing and is used by every module of the block.
package mte_pkg;

   localparam int TEMPO_FRAC_BITS = 8;

   localparam logic [63:0] TEMPO_DIVIDEND = 64'd60000000 << TEMPO_FRAC_BITS;
   localparam int DIVIDEND_W = $clog2(TEMPO_DIVIDEND + 64'd1);
   localparam int DIV_CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [23:0] TEMPO_MAX = 24'hFFFFFF;

   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] META_PREFIX     = 8'hFF;
   localparam logic [7:0] META_END        = 8'h2F;
   localparam logic [7:0] META_TEMPO      = 8'h51;
   localparam logic [7:0] META_TIMESIG    = 8'h58;
   localparam logic [7:0] LEN_TEMPO       = 8'h03;
   localparam logic [7:0] LEN_TIMESIG     = 8'h04;
   localparam logic [7:0] LEN_END         = 8'h00;

   localparam int BODY_MAX = 7;
   localparam logic [2:0] LAST_NOTE    = 3'd2;
   localparam logic [2:0] LAST_TIMESIG = 3'd6;
   localparam logic [2:0] LAST_TEMPO   = 3'd5;
   localparam logic [2:0] LAST_END     = 3'd2;
   localparam logic [2:0] TEMPO_HI_POS  = 3'd3;
   localparam logic [2:0] TEMPO_MID_POS = 3'd4;
   localparam logic [2:0] TEMPO_LO_POS  = 3'd5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_NOTE,
      MODE_TIMESIG,
      MODE_TEMPO,
      MODE_END
   } mode_type;

   typedef enum logic {
      PH_DELTA,
      PH_BODY
   } phase_type;

   typedef struct packed {
      mode_type                    mode;
      logic [1:0]                  groups_m1;
      logic [27:0]                 delta;
      logic [BODY_MAX-1:0][7:0]    body;
      logic [2:0]                  body_last;
      logic [23:0]                 bpm;
   } job_type;

   typedef struct packed {
      logic        start;
      logic [23:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [23:0] value;
   } div_rsp_type;

endpackage

// ----- design/mte_if.sv -----
// Channel interfaces of the track event encoder: the event request and the byte response.
// They depend on nothing; the field widths are those of the event and byte formats.
interface mte_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [27:0] delta_ticks;
   logic        note_on;
   logic [3:0]  channel;
   logic [6:0]  key;
   logic [6:0]  velocity;
   logic [7:0]  numerator;
   logic [7:0]  denominator;
   logic [7:0]  clocks_per_click;
   logic [7:0]  notated_per_quarter;
   logic [23:0] tempo_bpm_fx;

   modport source (
      output valid, mode, delta_ticks, note_on, channel, key, velocity, numerator,
             denominator, clocks_per_click, notated_per_quarter, tempo_bpm_fx,
      input  ready
   );
   modport sink (
      input  valid, mode, delta_ticks, note_on, channel, key, velocity, numerator,
             denominator, clocks_per_click, notated_per_quarter, tempo_bpm_fx,
      output ready
   );
endinterface

interface mte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- design/mte_front.sv -----
// Front end of the encoder: accepts events and turns each into a job for the queue.
// It depends on mte_pkg and the request interface.
module mte_front (
   mte_req_if.sink           req,
   input  logic              queue_full,
   output logic              push,
   output mte_pkg::job_type  job
);
   import mte_pkg::*;

   logic [2:0] den_log;
   mode_type   mode;

   assign mode = mode_type'(req.mode);
   assign req.ready = !queue_full;
   assign push = req.valid && !queue_full;

   always_comb begin
      den_log = 3'd0;
      if (req.denominator[7]) begin
         den_log = 3'd7;
      end else if (req.denominator[6]) begin
         den_log = 3'd6;
      end else if (req.denominator[5]) begin
         den_log = 3'd5;
      end else if (req.denominator[4]) begin
         den_log = 3'd4;
      end else if (req.denominator[3]) begin
         den_log = 3'd3;
      end else if (req.denominator[2]) begin
         den_log = 3'd2;
      end else if (req.denominator[1]) begin
         den_log = 3'd1;
      end
   end

   always_comb begin
      job = '0;
      job.mode = mode;
      job.delta = req.delta_ticks;
      job.bpm = req.tempo_bpm_fx;
      if (req.delta_ticks[27:21] != 7'd0) begin
         job.groups_m1 = 2'd3;
      end else if (req.delta_ticks[20:14] != 7'd0) begin
         job.groups_m1 = 2'd2;
      end else if (req.delta_ticks[13:7] != 7'd0) begin
         job.groups_m1 = 2'd1;
      end else begin
         job.groups_m1 = 2'd0;
      end
      case (mode)
         MODE_NOTE: begin
            job.body[0] = (req.note_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'h0, req.channel};
            job.body[1] = {1'b0, req.key};
            job.body[2] = {1'b0, req.velocity};
            job.body_last = LAST_NOTE;
         end
         MODE_TIMESIG: begin
            job.body[0] = META_PREFIX;
            job.body[1] = META_TIMESIG;
            job.body[2] = LEN_TIMESIG;
            job.body[3] = req.numerator;
            job.body[4] = {5'd0, den_log};
            job.body[5] = req.clocks_per_click;
            job.body[6] = req.notated_per_quarter;
            job.body_last = LAST_TIMESIG;
         end
         MODE_TEMPO: begin
            job.body[0] = META_PREFIX;
            job.body[1] = META_TEMPO;
            job.body[2] = LEN_TEMPO;
            job.body_last = LAST_TEMPO;
         end
         default: begin
            job.body[0] = META_PREFIX;
            job.body[1] = META_END;
            job.body[2] = LEN_END;
            job.body_last = LAST_END;
         end
      endcase
   end

endmodule

// ----- design/mte_queue.sv -----
// Short job queue between the front and back ends of the encoder.
// It depends on mte_pkg for the job type and the queue depth.
module mte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mte_pkg::job_type  job_in,
   output logic              full,
   input  logic              pop,
   output mte_pkg::job_type  head,
   output logic              not_empty
);
   import mte_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

   assign full = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ----- design/mte_divider.sv -----
// Restoring divider for the tempo value: the fixed microseconds-per-minute dividend over
// the tempo, one quotient bit a cycle, saturated to 24 bits. It depends on mte_pkg.
module mte_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mte_pkg::div_req_type  div_req,
   output mte_pkg::div_rsp_type  div_rsp
);
   import mte_pkg::*;

   logic [23:0]            rem_ff;
   logic [23:0]            rem_in;
   logic [DIVIDEND_W-1:0]  dq_ff;
   logic [DIVIDEND_W-1:0]  dq_in;
   logic [DIV_CNT_W-1:0]   cnt_ff;
   logic [DIV_CNT_W-1:0]   cnt_in;
   logic [23:0]            divisor_ff;
   logic [23:0]            divisor_in;
   logic                   run_ff;
   logic                   run_in;
   logic                   done_ff;
   logic                   done_in;
   logic [24:0]            trial;
   logic [24:0]            diff;
   logic                   fits;

   assign trial = {rem_ff, dq_ff[DIVIDEND_W-1]};
   assign diff = trial - {1'b0, divisor_ff};
   assign fits = (trial >= {1'b0, divisor_ff});

   always_comb begin
      rem_in = rem_ff;
      dq_in = dq_ff;
      cnt_in = cnt_ff;
      divisor_in = divisor_ff;
      run_in = run_ff;
      done_in = done_ff;
      if (div_req.start) begin
         rem_in = '0;
         dq_in = TEMPO_DIVIDEND[DIVIDEND_W-1:0];
         cnt_in = DIV_CNT_W'(DIVIDEND_W);
         divisor_in = div_req.divisor;
         run_in = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         rem_in = fits ? diff[23:0] : trial[23:0];
         dq_in = {dq_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff <= dq_in;
      cnt_ff <= cnt_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.value = (dq_ff[DIVIDEND_W-1:24] != '0) ? TEMPO_MAX : dq_ff[23:0];

endmodule

// ----- design/mte_back.sv -----
// Back end of the encoder: takes jobs from the queue and sends their bytes, delta time
// first, through an output register. It depends on mte_pkg and the response interface.
module mte_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  not_empty,
   input  mte_pkg::job_type      head,
   output logic                  pop,
   output mte_pkg::div_req_type  div_req,
   input  mte_pkg::div_rsp_type  div_rsp,
   mte_rsp_if.source             rsp
);
   import mte_pkg::*;

   job_type    job_ff;
   job_type    job_in;
   logic       busy_ff;
   logic       busy_in;
   phase_type  phase_ff;
   phase_type  phase_in;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic [7:0] out_byte_ff;
   logic [7:0] out_byte_in;
   logic       out_last_ff;
   logic       out_last_in;
   logic [7:0] cur_byte;
   logic       cur_last;
   logic       is_value;
   logic       slot_free;
   logic       fire;

   assign is_value = (job_ff.mode == MODE_TEMPO) && (phase_ff == PH_BODY)
                     && (idx_ff >= TEMPO_HI_POS);
   assign cur_last = (phase_ff == PH_BODY) && (idx_ff == job_ff.body_last);
   assign slot_free = !out_valid_ff || rsp.ready;
   assign fire = busy_ff && slot_free && !(is_value && !div_rsp.done);

   always_comb begin
      cur_byte = job_ff.body[idx_ff];
      if (phase_ff == PH_DELTA) begin
         case (idx_ff[1:0])
            2'd0:    cur_byte = {1'b0, job_ff.delta[6:0]};
            2'd1:    cur_byte = {1'b1, job_ff.delta[13:7]};
            2'd2:    cur_byte = {1'b1, job_ff.delta[20:14]};
            default: cur_byte = {1'b1, job_ff.delta[27:21]};
         endcase
      end else if (is_value) begin
         case (idx_ff)
            TEMPO_HI_POS:  cur_byte = div_rsp.value[23:16];
            TEMPO_MID_POS: cur_byte = div_rsp.value[15:8];
            default:       cur_byte = div_rsp.value[7:0];
         endcase
      end
   end

   always_comb begin
      job_in = job_ff;
      busy_in = busy_ff;
      phase_in = phase_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      pop = 1'b0;
      div_req = '0;
      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
         out_byte_in = cur_byte;
         out_last_in = cur_last;
         case (phase_ff)
            PH_DELTA: begin
               if (idx_ff == 3'd0) begin
                  phase_in = PH_BODY;
               end else begin
                  idx_in = idx_ff - 3'd1;
               end
            end
            default: begin
               if (cur_last) begin
                  busy_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         endcase
      end
      if (not_empty && (!busy_ff || (fire && cur_last))) begin
         pop = 1'b1;
         job_in = head;
         busy_in = 1'b1;
         phase_in = PH_DELTA;
         idx_in = {1'b0, head.groups_m1};
         div_req.start = (head.mode == MODE_TEMPO);
         div_req.divisor = head.bpm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         phase_ff <= PH_DELTA;
         idx_ff <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.last = out_last_ff;

endmodule

// ----- design/midi_track_event_encoder.sv -----
// Top level of the track event encoder: front end, job queue, tempo divider and back end.
// It depends on mte_pkg, the channel interfaces and the mte_* modules.
//
//   channel   port      direction   beat
//   request   req_bus   in          one track event
//   response  rsp_bus   out         one file byte, last set on the final byte of an event
//
// The back end sends one byte a cycle while the response is ready and no tempo value is
// awaited; an event is 1 to 4 delta bytes and 3 to 7 body bytes. A tempo event waits on
// the divider, which starts when the event leaves the queue, before its three value bytes
// go out. Reset is synchronous and clears the queue, the back end and the divider control.
// The queue holds two events, so requests are taken while the back end works; a stalled
// response beat holds in the output register.
module midi_track_event_encoder (
   input  logic        clock,
   input  logic        reset,
   mte_req_if.sink     req_bus,
   mte_rsp_if.source   rsp_bus
);
   import mte_pkg::*;

   job_type      front_job;
   job_type      queue_head;
   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_not_empty;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   mte_front u_front (
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   mte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .job_in    (front_job),
      .full      (queue_full),
      .pop       (pop),
      .head      (queue_head),
      .not_empty (queue_not_empty)
   );

   mte_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mte_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .head      (queue_head),
      .pop       (pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp       (rsp_bus)
   );

endmodule

// ----- tb/mte_event_checker.sv -----
`timescale 1ns / 1ps
// Byte stream checker for the track event encoder: watches both channels, predicts the
// file bytes of every accepted event and compares them with the response beats.
// It depends on mte_pkg and the channel interfaces mte_req_if and mte_rsp_if.
module mte_event_checker (
   input  logic  clock,
   input  logic  reset,
   mte_req_if    req_bus,
   mte_rsp_if    rsp_bus,
   output int    fail_count,
   output int    pending,
   output int    bytes_checked
);
   import mte_pkg::*;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } file_byte_type;

   localparam logic [63:0] USEC_PER_MINUTE = 64'd60000000;

   file_byte_type expected_bytes[$];

   function automatic logic [7:0] denominator_log2(logic [7:0] denominator);
      logic [7:0] v;
      logic [7:0] r;
      v = denominator;
      r = 8'd0;
      while (v > 8'd1) begin
         v = v >> 1;
         r = r + 8'd1;
      end
      return r;
   endfunction

   function automatic logic [23:0] usec_per_quarter(logic [23:0] bpm_fx);
      logic [63:0] q;
      if (bpm_fx == 24'd0) begin
         return 24'hFFFFFF;
      end
      q = (USEC_PER_MINUTE << TEMPO_FRAC_BITS) / {40'd0, bpm_fx};
      return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
   endfunction

   function automatic void encode_event(
      mode_type    mode,
      logic [27:0] delta,
      logic        note_on,
      logic [3:0]  channel,
      logic [6:0]  key,
      logic [6:0]  velocity,
      logic [7:0]  numerator,
      logic [7:0]  denominator,
      logic [7:0]  clocks,
      logic [7:0]  notated,
      logic [23:0] bpm_fx
   );
      logic [7:0]    bytes[$];
      int            groups;
      logic [27:0]   part;
      logic [23:0]   usec;
      file_byte_type fb;
      groups = 1;
      while (groups < 4 && (delta >> (7 * groups)) != 28'd0) begin
         groups++;
      end
      for (int g = groups - 1; g >= 0; g--) begin
         part = (delta >> (7 * g)) & 28'h7F;
         bytes.push_back(g > 0 ? (part[7:0] | 8'h80) : part[7:0]);
      end
      case (mode)
         MODE_NOTE: begin
            bytes.push_back((note_on ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'd0, channel});
            bytes.push_back({1'b0, key});
            bytes.push_back({1'b0, velocity});
         end
         MODE_TIMESIG: begin
            bytes.push_back(META_PREFIX);
            bytes.push_back(META_TIMESIG);
            bytes.push_back(LEN_TIMESIG);
            bytes.push_back(numerator);
            bytes.push_back(denominator_log2(denominator));
            bytes.push_back(clocks);
            bytes.push_back(notated);
         end
         MODE_TEMPO: begin
            usec = usec_per_quarter(bpm_fx);
            bytes.push_back(META_PREFIX);
            bytes.push_back(META_TEMPO);
            bytes.push_back(LEN_TEMPO);
            bytes.push_back(usec[23:16]);
            bytes.push_back(usec[15:8]);
            bytes.push_back(usec[7:0]);
         end
         default: begin
            bytes.push_back(META_PREFIX);
            bytes.push_back(META_END);
            bytes.push_back(LEN_END);
         end
      endcase
      foreach (bytes[k]) begin
         fb.value = bytes[k];
         fb.last  = (k == bytes.size() - 1);
         expected_bytes.push_back(fb);
      end
   endfunction

   always @(posedge clock) begin
      file_byte_type want;
      if (reset) begin
         fail_count    = 0;
         pending       = 0;
         bytes_checked = 0;
         expected_bytes.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            encode_event(mode_type'(req_bus.mode), req_bus.delta_ticks, req_bus.note_on,
                         req_bus.channel, req_bus.key, req_bus.velocity, req_bus.numerator,
                         req_bus.denominator, req_bus.clocks_per_click,
                         req_bus.notated_per_quarter, req_bus.tempo_bpm_fx);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               $display("%0t: byte beat with nothing expected, got out_byte %02h last %0b",
                        $time, rsp_bus.out_byte, rsp_bus.last);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_bus.out_byte !== want.value) begin
                  $display("%0t: out_byte expected %02h, actual %02h",
                           $time, want.value, rsp_bus.out_byte);
                  fail_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last expected %0b, actual %0b",
                           $time, want.last, rsp_bus.last);
                  fail_count++;
               end
            end
         end
         pending = expected_bytes.size();
      end
   end

endmodule

// ----- tb/midi_track_event_encoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the track event encoder: drives directed and random track events,
// stalls the byte stream at random and gives the verdict from the checker's count.
// It depends on mte_pkg, the channel interfaces, mte_event_checker and the block itself.
module midi_track_event_encoder_tb;
   import mte_pkg::*;

   typedef struct {
      mode_type    mode;
      logic [27:0] delta;
      logic        note_on;
      logic [3:0]  channel;
      logic [6:0]  key;
      logic [6:0]  velocity;
      logic [7:0]  numerator;
      logic [7:0]  denominator;
      logic [7:0]  clocks;
      logic [7:0]  notated;
      logic [23:0] bpm_fx;
   } track_event_type;

   localparam int RANDOM_EVENTS = 460;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   bytes_checked;
   int   events_sent;
   int   mode_count[4];
   logic req_calm;
   logic rsp_calm;

   mte_req_if req_bus ();
   mte_rsp_if rsp_bus ();

   midi_track_event_encoder uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mte_event_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending       (pending),
      .bytes_checked (bytes_checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d bytes still expected.", pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic int idle_cycles(logic calm);
      if (calm) begin
         return 0;
      end
      return int'($urandom_range(0, 12));
   endfunction

   function automatic track_event_type base_event(mode_type mode, logic [27:0] delta);
      track_event_type ev;
      ev.mode        = mode;
      ev.delta       = delta;
      ev.note_on     = 1'($urandom_range(0, 1));
      ev.channel     = 4'($urandom_range(0, 15));
      ev.key         = 7'($urandom_range(0, 127));
      ev.velocity    = 7'($urandom_range(0, 127));
      ev.numerator   = 8'($urandom_range(0, 255));
      ev.denominator = 8'($urandom_range(0, 255));
      ev.clocks      = 8'($urandom_range(0, 255));
      ev.notated     = 8'($urandom_range(0, 255));
      ev.bpm_fx      = 24'($urandom_range(0, 24'hFFFFFF));
      return ev;
   endfunction

   task automatic send_event(track_event_type ev);
      int gap;
      if ($urandom_range(0, 19) == 0) begin
         req_calm = !req_calm;
      end
      gap = idle_cycles(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid               <= 1'b1;
      req_bus.mode                <= ev.mode;
      req_bus.delta_ticks         <= ev.delta;
      req_bus.note_on             <= ev.note_on;
      req_bus.channel             <= ev.channel;
      req_bus.key                 <= ev.key;
      req_bus.velocity            <= ev.velocity;
      req_bus.numerator           <= ev.numerator;
      req_bus.denominator         <= ev.denominator;
      req_bus.clocks_per_click    <= ev.clocks;
      req_bus.notated_per_quarter <= ev.notated;
      req_bus.tempo_bpm_fx        <= ev.bpm_fx;
      do @(posedge clock); while (!req_bus.ready);
      events_sent++;
      mode_count[ev.mode]++;
   endtask

   task automatic send_note(logic [27:0] delta, logic note_on, logic [3:0] channel,
                            logic [6:0] key, logic [6:0] velocity);
      track_event_type ev;
      ev = base_event(MODE_NOTE, delta);
      ev.note_on  = note_on;
      ev.channel  = channel;
      ev.key      = key;
      ev.velocity = velocity;
      send_event(ev);
   endtask

   task automatic send_timesig(logic [27:0] delta, logic [7:0] numerator,
                               logic [7:0] denominator, logic [7:0] clocks,
                               logic [7:0] notated);
      track_event_type ev;
      ev = base_event(MODE_TIMESIG, delta);
      ev.numerator   = numerator;
      ev.denominator = denominator;
      ev.clocks      = clocks;
      ev.notated     = notated;
      send_event(ev);
   endtask

   task automatic send_tempo(logic [27:0] delta, logic [23:0] bpm_fx);
      track_event_type ev;
      ev = base_event(MODE_TEMPO, delta);
      ev.bpm_fx = bpm_fx;
      send_event(ev);
   endtask

   task automatic send_end(logic [27:0] delta);
      send_event(base_event(MODE_END, delta));
   endtask

   function automatic logic [27:0] random_delta();
      if ($urandom_range(0, 7) == 0) begin
         return 28'd0;
      end
      case ($urandom_range(1, 4))
         1:       return 28'($urandom_range(0, 127));
         2:       return 28'($urandom_range(128, 16383));
         3:       return 28'($urandom_range(16384, 2097151));
         default: return 28'($urandom_range(2097152, 28'hFFFFFFF));
      endcase
   endfunction

   function automatic logic [7:0] random_denominator();
      if ($urandom_range(0, 3) != 0) begin
         return 8'd1 << $urandom_range(0, 7);
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [23:0] random_tempo();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return 24'($urandom_range(20 * 256, 400 * 256));
         4, 5:       return 24'($urandom_range(0, 24'hFFFFFF));
         6:          return 24'($urandom_range(0, 1024));
         default:    return 24'($urandom_range(900, 930));
      endcase
   endfunction

   // Response side: before each beat ready may drop for a random gap; in calm stretches it stays high.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      rsp_calm = 1'b0;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_calm = !rsp_calm;
         end
         gap = idle_cycles(rsp_calm);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      int guard;
      track_event_type ev;
      events_sent                 = 0;
      mode_count                  = '{default: 0};
      req_calm                    = 1'b0;
      reset                       <= 1'b1;
      req_bus.valid               <= 1'b0;
      req_bus.mode                <= MODE_NOTE;
      req_bus.delta_ticks         <= '0;
      req_bus.note_on             <= 1'b0;
      req_bus.channel             <= '0;
      req_bus.key                 <= '0;
      req_bus.velocity            <= '0;
      req_bus.numerator           <= '0;
      req_bus.denominator         <= '0;
      req_bus.clocks_per_click    <= '0;
      req_bus.notated_per_quarter <= '0;
      req_bus.tempo_bpm_fx        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Delta lengths at each group boundary, with the note fields at their extremes and in between.
      send_note(28'd0, 1'b1, 4'd0, 7'd0, 7'd0);
      send_note(28'd127, 1'b0, 4'd15, 7'd127, 7'd127);
      send_note(28'd128, 1'b1, 4'd15, 7'd127, 7'd0);
      send_note(28'd16383, 1'b0, 4'd0, 7'd0, 7'd127);
      send_note(28'd16384, 1'b1, 4'd9, 7'd60, 7'd100);
      send_note(28'd2097151, 1'b0, 4'd5, 7'd64, 7'd64);
      send_note(28'd2097152, 1'b1, 4'd3, 7'd1, 7'd1);
      send_note(28'hFFFFFFF, 1'b0, 4'd10, 7'd126, 7'd126);
      // Time signatures, including a zero and a non-power-of-two denominator.
      send_timesig(28'd0, 8'd4, 8'd4, 8'd24, 8'd8);
      send_timesig(28'd96, 8'd0, 8'd1, 8'd0, 8'd0);
      send_timesig(28'hFFFFFFF, 8'd255, 8'd128, 8'd255, 8'd255);
      send_timesig(28'd480, 8'd7, 8'd0, 8'd36, 8'd8);
      send_timesig(28'd1, 8'd3, 8'd3, 8'd12, 8'd8);
      send_timesig(28'd200, 8'd5, 8'd255, 8'd1, 8'd1);
      // Tempi: zero, the slowest, either side of saturation, a common one and the fastest.
      send_tempo(28'd0, 24'd0);
      send_tempo(28'd10, 24'd1);
      send_tempo(28'd20000, 24'd915);
      send_tempo(28'd300, 24'd916);
      send_tempo(28'd0, 24'd120 << 8);
      send_tempo(28'hFFFFFFF, 24'hFFFFFF);
      send_end(28'd0);
      send_end(28'hFFFFFFF);
      send_end(28'd16384);

      for (int i = 0; i < RANDOM_EVENTS; i++) begin
         ev = base_event(mode_type'(2'($urandom_range(0, 3))), random_delta());
         ev.denominator = random_denominator();
         ev.bpm_fx      = random_tempo();
         send_event(ev);
      end
      req_bus.valid <= 1'b0;

      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending != 0 && guard < 200000);
      repeat (3 * DIVIDEND_W) @(posedge clock);

      $display("Sent %0d events (%0d note, %0d time signature, %0d tempo, %0d end of track).",
               events_sent, mode_count[MODE_NOTE], mode_count[MODE_TIMESIG],
               mode_count[MODE_TEMPO], mode_count[MODE_END]);
      $display("Checked %0d byte beats; %0d bytes still expected.", bytes_checked, pending);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
